[sv/sha_pkg.sv]
// Shared types, constants and functions of the SHA-256 message hasher.
package sha_pkg;

  // Block geometry and padding positions
  localparam logic [5:0] BlockLastByte = 6'd63;
  localparam logic [5:0] LenFirstByte  = 6'd56;
  localparam logic [6:0] RoundCount    = 7'd64;
  localparam logic [6:0] DirectWords   = 7'd16;
  localparam logic [7:0] PadMarker     = 8'h80;
  localparam logic [63:0] BitsPerByte  = 64'd8;
  localparam logic [2:0] LastWordIdx   = 3'd7;
  localparam int unsigned SchedDepth   = 16;
  localparam int unsigned WordWidth    = 32;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_FEED,
    S_PAD80,
    S_PADZ,
    S_PADL,
    S_OUT
  } sha_state_e;

  // Controls for the schedule memory side
  typedef struct packed {
    logic       put_en;
    logic [7:0] put_byte;
    logic [5:0] put_pos;
    logic       sched_en;
    logic [6:0] sched_idx;
    logic [6:0] rd_idx;
  } sched_ctrl_t;

  // Controls for the compression datapath
  typedef struct packed {
    logic       load;
    logic       step;
    logic       feed;
    logic       init;
    logic [5:0] rnd_idx;
    logic [2:0] rd_word;
  } round_ctrl_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  // Byte of the bit length for tail positions 56..63, big-endian
  function automatic logic [7:0] len_byte(input logic [63:0] len, input logic [2:0] pos);
    logic [63:0] sh;
    sh = len >> {~pos, 3'b000};
    return sh[7:0];
  endfunction

  // Initial hash value
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

[sv/sha_ram.sv]
// Generic RAM: one write port, two registered read ports.
module sha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[sv/sha_sched.sv]
// Message schedule: byte packing into the 16-word window RAM and word expansion.
module sha_sched (
  input  logic                clk_i,
  input  sha_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]         w_o
);

  localparam int unsigned AddrW = $clog2(sha_pkg::SchedDepth);

  logic [23:0] acc_q;
  logic [31:0] x16_q, w1_q, w2_q;
  logic [31:0] word_put, w_new, rd_a, rd_b;
  logic        we;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0] wdata;
  logic        direct;

  // Byte packing: word completes on its fourth byte
  assign word_put = {acc_q, ctrl_i.put_byte};

  // Early rounds read stored words, later ones expand
  assign direct = ctrl_i.sched_idx < sha_pkg::DirectWords;
  assign w_new  = direct ? rd_b
                : x16_q + sha_pkg::ssig0(rd_a) + rd_b + sha_pkg::ssig1(w2_q);

  // Write port shared by packing and expansion
  assign we    = (ctrl_i.put_en && (ctrl_i.put_pos[1:0] == 2'b11))
               || (ctrl_i.sched_en && !direct);
  assign waddr = ctrl_i.sched_en ? ctrl_i.sched_idx[AddrW-1:0] : ctrl_i.put_pos[5:2];
  assign wdata = ctrl_i.sched_en ? w_new : word_put;

  // Reads for the next index: W[t-15] on port A, W[t] or W[t-7] on port B
  assign raddr_a = ctrl_i.rd_idx[AddrW-1:0] + AddrW'(1);
  assign raddr_b = (ctrl_i.rd_idx < sha_pkg::DirectWords) ? ctrl_i.rd_idx[AddrW-1:0]
                 : ctrl_i.rd_idx[AddrW-1:0] + AddrW'(9);

  sha_ram #(
    .WIDTH(sha_pkg::WordWidth),
    .DEPTH(sha_pkg::SchedDepth)
  ) u_window (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // History: W[t-16] from last port A read, W[t-1] and W[t-2] forwarded
  always_ff @(posedge clk_i) begin
    if (ctrl_i.put_en) begin
      acc_q <= word_put[23:0];
    end
    if (ctrl_i.sched_en) begin
      x16_q <= rd_a;
      w2_q  <= w1_q;
      w1_q  <= w_new;
    end
  end

  assign w_o = w1_q;

endmodule

[sv/sha_round.sv]
// Compression datapath: working variables, round logic and chaining value.
module sha_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha_pkg::round_ctrl_t ctrl_i,
  input  logic [31:0]          w_i,
  output logic [31:0]          digest_o
);

  logic [31:0] v_q [8];
  logic [31:0] chain_q [8];
  logic [31:0] t1, t2, ch, maj;

  // One SHA-256 round on a..h
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch
             + sha_pkg::round_k(ctrl_i.rnd_idx) + w_i;
  assign t2  = sha_pkg::bsig0(v_q[0]) + maj;

  // Working variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= '0;
      end
    end else if (ctrl_i.load) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= chain_q[i];
      end
    end else if (ctrl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chaining value: feed-forward after a block, initial hash per message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha_pkg::iv_word(3'(i));
      end
    end else if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha_pkg::iv_word(3'(i));
      end
    end else if (ctrl_i.feed) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + v_q[i];
      end
    end
  end

  assign digest_o = chain_q[ctrl_i.rd_word];

endmodule

[sv/sha256_message_hash.sv]
// Top level of the SHA-256 message hasher: controller, padding and digest output.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------
//   in      | in_valid_i | in_stall_o  | data_byte_i, byte_present_i, end_of_message_i
//   out     | out_valid_o| out_stall_i | digest_word_o, word_index_o, last_word_o
//
// A request is taken while the controller is idle; a request that fills a 64-byte
// block then adds a read prime, a run with the schedule one index ahead of the 64
// rounds, and a feed-forward. End of message: padding plus one or two blocks, then
// eight digest words, one per cycle the output is not stalled.
// Reset loads the initial hash and clears counters; the schedule RAM is not cleared.
// in_stall_o is high whenever the controller is not idle.
module sha256_message_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_pkg::sha_state_e state_q, state_d, ret_q, ret_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [6:0]  s_q, s_d;
  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] digest_word_q;
  logic [2:0]  word_index_q;
  logic        last_word_q;
  logic        in_acc, out_load;
  logic [31:0] digest;
  logic [31:0] w_cur;
  sha_pkg::sched_ctrl_t sc;
  sha_pkg::round_ctrl_t rc;

  assign in_stall_o = (state_q != sha_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Next state and datapath controls
  always_comb begin
    sha_pkg::sha_state_e nxt;
    nxt          = sha_pkg::S_IDLE;
    state_d      = state_q;
    ret_d        = ret_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    s_d          = s_q;
    k_d          = k_q;
    out_load     = 1'b0;
    sc           = '0;
    sc.put_pos   = cnt_q;
    rc           = '0;
    rc.rnd_idx   = 6'(s_q - 7'd1);
    rc.rd_word   = k_q;

    unique case (state_q)
      sha_pkg::S_IDLE: begin
        if (in_acc) begin
          nxt = end_of_message_i ? sha_pkg::S_PAD80 : sha_pkg::S_IDLE;
          state_d = nxt;
          if (byte_present_i) begin
            sc.put_en   = 1'b1;
            sc.put_byte = data_byte_i;
            len_d       = len_q + sha_pkg::BitsPerByte;
            if (cnt_q == sha_pkg::BlockLastByte) begin
              state_d = sha_pkg::S_LOAD;
              ret_d   = nxt;
            end
          end
        end
      end
      sha_pkg::S_PAD80: begin
        sc.put_en   = 1'b1;
        sc.put_byte = sha_pkg::PadMarker;
        state_d     = sha_pkg::S_PADZ;
        if (cnt_q == sha_pkg::BlockLastByte) begin
          state_d = sha_pkg::S_LOAD;
          ret_d   = sha_pkg::S_PADZ;
        end
      end
      sha_pkg::S_PADZ: begin
        if (cnt_q == sha_pkg::LenFirstByte) begin
          state_d = sha_pkg::S_PADL;
        end else begin
          sc.put_en = 1'b1;
          if (cnt_q == sha_pkg::BlockLastByte) begin
            state_d = sha_pkg::S_LOAD;
            ret_d   = sha_pkg::S_PADZ;
          end
        end
      end
      sha_pkg::S_PADL: begin
        sc.put_en   = 1'b1;
        sc.put_byte = sha_pkg::len_byte(len_q, cnt_q[2:0]);
        if (cnt_q == sha_pkg::BlockLastByte) begin
          state_d = sha_pkg::S_LOAD;
          ret_d   = sha_pkg::S_OUT;
        end
      end
      sha_pkg::S_LOAD: begin
        // Prime the reads for index zero and copy the chaining value
        rc.load   = 1'b1;
        sc.rd_idx = '0;
        s_d       = '0;
        state_d   = sha_pkg::S_RUN;
      end
      sha_pkg::S_RUN: begin
        // Schedule runs one index ahead of the rounds
        sc.sched_en  = (s_q < sha_pkg::RoundCount);
        sc.sched_idx = s_q;
        sc.rd_idx    = s_q + 7'd1;
        rc.step      = (s_q != '0);
        if (s_q == sha_pkg::RoundCount) begin
          s_d     = '0;
          state_d = sha_pkg::S_FEED;
        end else begin
          s_d = s_q + 7'd1;
        end
      end
      sha_pkg::S_FEED: begin
        rc.feed = 1'b1;
        state_d = ret_q;
      end
      sha_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          k_d      = k_q + 3'd1;
          if (k_q == sha_pkg::LastWordIdx) begin
            rc.init = 1'b1;
            len_d   = '0;
            state_d = sha_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = sha_pkg::S_IDLE;
      end
    endcase

    if (sc.put_en) begin
      cnt_d = cnt_q + 6'd1;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::S_IDLE;
      ret_q       <= sha_pkg::S_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      s_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      s_q         <= s_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digest_word_q <= digest;
      word_index_q  <= k_q;
      last_word_q   <= (k_q == sha_pkg::LastWordIdx);
    end
  end

  sha_sched u_sched (
    .clk_i (clk_i),
    .ctrl_i(sc),
    .w_o   (w_cur)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rc),
    .w_i     (w_cur),
    .digest_o(digest)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_word_q;
  assign word_index_o  = word_index_q;
  assign last_word_o   = last_word_q;

endmodule

[sim/tb_sha256_message_hash.sv]
// Self-checking testbench for the SHA-256 message hasher with a built-in digest predictor.
`timescale 1ns / 100ps

module tb_sha256_message_hash;

  // Pacing of the two channels over the run
  typedef enum int {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL_RATE
  } pace_e;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
  } digest_word_t;

  localparam int HoldCycles   = 400;
  localparam int RandomItems  = 150;
  localparam int DrainCycles  = 200;
  localparam int ByteMax      = 255;

  // Digest scoreboard: keeps its own hash state and the queue of pending digest words
  class sha256_scoreboard;
    bit [31:0]    chain[8];
    bit [31:0]    sched[16];
    bit [31:0]    rk[64];
    bit [5:0]     fill;
    bit [63:0]    msg_bits;
    digest_word_t digest_q[$];
    int           errors;

    function new();
      rk = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      foreach (sched[i]) sched[i] = '0;
      errors = 0;
      restart();
    endfunction

    // Back to the initial hash for a fresh message
    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill = '0;
      msg_bits = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the rolling schedule, then feed-forward into the chain
    function void compress();
      bit [31:0] v[8];
      bit [31:0] w, x15, x2, s0, s1, t1, t2;
      v = chain;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w = sched[t];
        end else begin
          x15 = sched[(t - 15) & 15];
          x2  = sched[(t - 2) & 15];
          s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
          s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
          w   = sched[t & 15] + s0 + sched[(t - 7) & 15] + s1;
          sched[t & 15] = w;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk[t] + w;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Pack one byte big-endian into the block; a full block is compressed
    function void absorb(bit [7:0] b);
      sched[fill[5:2]] = {sched[fill[5:2]][23:0], b};
      fill = fill + 6'd1;
      if (fill == 6'd0) compress();
    endfunction

    // Accepted request: update the hash; at end of message queue the digest
    function void note_request(logic [7:0] data, logic present, logic eom);
      bit [63:0] len;
      if (present) begin
        absorb(data);
        msg_bits = msg_bits + 64'd8;
      end
      if (!eom) return;
      len = msg_bits;
      absorb(8'h80);
      while (fill != 6'd56) absorb(8'h00);
      for (int s = 56; s >= 0; s -= 8) absorb(len[s +: 8]);
      for (int i = 0; i < 8; i++) begin
        digest_q.push_back('{word: chain[i], idx: i[2:0], last: (i == 7)});
      end
      restart();
    endfunction

    // Accepted digest word against the oldest pending one
    function void check_digest(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t want;
      if (digest_q.size() == 0) begin
        $error("digest word %h (index %0d) with nothing pending", word, idx);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) begin
        $error("digest_word: expected %h, actual %h", want.word, word);
        errors++;
      end
      if (idx !== want.idx) begin
        $error("word_index: expected %0d, actual %0d", want.idx, idx);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_word: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_scoreboard sb = new();
  pace_e pace = PACE_SLOW_SINK;
  int    items_sent = 0;
  int    random_start = 0;

  sha256_message_hash i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_word_o   (digest_word_o),
    .word_index_o    (word_index_o),
    .last_word_o     (last_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [7:0] data, input logic present, input logic eom);
    int gap_pct;
    gap_pct = (pace == PACE_SLOW_SINK) ? 32 : (pace == PACE_SLOW_SOURCE) ? 52 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i  = 1'b0;
      data_byte_i = 8'($urandom_range(0, ByteMax));
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    data_byte_i      = data;
    byte_present_i   = present;
    end_of_message_i = eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(data, present, eom);
    if (present || eom) items_sent++;
    if (items_sent - random_start >= 2 * RandomItems / 3 && random_start > 0) begin
      pace = PACE_FULL_RATE;
    end else if (items_sent - random_start >= RandomItems / 3 && random_start > 0) begin
      pace = PACE_SLOW_SOURCE;
    end
    @(negedge clk_i);
  endtask

  // One message of len bytes with random content and occasional empty requests
  task automatic send_message(input int len);
    int tail_byte;
    tail_byte = (len > 0) ? $urandom_range(0, 1) : 0;
    for (int i = 0; i < len - tail_byte; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom_range(0, ByteMax)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, ByteMax)), 1'b1, 1'b0);
    end
    send_request(8'($urandom_range(0, ByteMax)), tail_byte[0], 1'b1);
  endtask

  // Output side: stall at the falling edge, take digest words at the rising edge
  initial begin
    int  hold_left;
    bit  hold_done;
    int  stall_pct;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      // one long hold-off once the full-rate pass starts, so the block backs up
      if (pace == PACE_FULL_RATE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      stall_pct = (pace == PACE_SLOW_SINK) ? 52 : (pace == PACE_SLOW_SOURCE) ? 32 : 0;
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < stall_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_digest(digest_word_o, word_index_o, last_word_o);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int boundary_lens[6];
    int len;
    int msg_no;
    boundary_lens = '{55, 56, 63, 64, 119, 120};
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = '0;
    byte_present_i   = 1'b0;
    end_of_message_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty message, empty request, "abc" with byte on the end request,
    // zero byte with a bare end, all-ones byte with end, empty again
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);

    // random messages; padding that fits one block and one that spills first
    random_start = items_sent;
    msg_no = 0;
    while (items_sent - random_start < RandomItems) begin
      if (msg_no == 0) begin
        len = 55;
      end else if (msg_no == 1) begin
        len = 56;
      end else if ($urandom_range(0, 7) == 0) begin
        len = boundary_lens[$urandom_range(0, 5)];
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
      msg_no++;
    end
    in_valid_i = 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("sha256_message_hash regression: pass");
    end else begin
      $display("sha256_message_hash regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("sha256_message_hash regression: fail");
    $finish;
  end

endmodule
